// ----- hdl/pms_pkg.sv -----
// ----------------------------------------------------------------------------
// pms_pkg: shared types and constants for the power meter sample scaler
// Field widths, register indexes and the thresholds used by the scaling path.
// ----------------------------------------------------------------------------
`default_nettype none

package pms_pkg;

	// input field widths
	localparam int unsigned CurW  = 24;
	localparam int unsigned VoltW = 24;
	localparam int unsigned FreqW = 16;
	localparam int unsigned PwrW  = 32;

	// output field widths
	localparam int unsigned ScaledW = 27;
	localparam int unsigned FreqOutW = 15;
	localparam int unsigned TotalW = 32;

	// configuration port
	localparam int unsigned CfgDataW = 24;
	typedef logic [1:0] cfg_idx_t;
	typedef logic [CfgDataW-1:0] cfg_data_t;

	localparam cfg_idx_t CfgCurrentDivisor = 2'd0;
	localparam cfg_idx_t CfgVoltageDivisor = 2'd1;
	localparam cfg_idx_t CfgPowerDivisor   = 2'd2;
	localparam cfg_idx_t CfgDropSmallPower = 2'd3;

	// shared divider: 35-bit dividend (ten times a 31-bit power), 24-bit divisor
	localparam int unsigned DivW   = 35;
	localparam int unsigned DvsrW  = 24;
	localparam int unsigned CntW   = 6;
	// bits of quotient produced per division kind
	localparam logic [CntW-1:0] NarrowSteps = 6'd27;
	localparam logic [CntW-1:0] WideSteps   = 6'd35;
	localparam logic [CntW-1:0] EnergySteps = 6'd22;

	localparam logic [DvsrW-1:0] ScaleDivisor = 24'd10;
	localparam logic [PwrW-1:0]  SmallPower   = 32'd500;
	localparam logic [PwrW-1:0]  PowerLimit   = 32'd4000000;

endpackage

`default_nettype wire

// ----- hdl/pms_if.sv -----
// ----------------------------------------------------------------------------
// pms_if: sample and result channels of the power meter sample scaler
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pms_sample_if;
	import pms_pkg::*;

	logic                valid;
	logic                ready;
	logic [CurW-1:0]     raw_current;
	logic [VoltW-1:0]    raw_voltage;
	logic [FreqW-1:0]    raw_frequency;
	logic [PwrW-1:0]     raw_power;
	logic                outlet_on;

	modport source (
		output valid, raw_current, raw_voltage, raw_frequency, raw_power, outlet_on,
		input  ready
	);
	modport sink (
		input  valid, raw_current, raw_voltage, raw_frequency, raw_power, outlet_on,
		output ready
	);
endinterface

interface pms_result_if;
	import pms_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ScaledW-1:0]   scaled_current;
	logic [ScaledW-1:0]   scaled_voltage;
	logic [PwrW-1:0]      scaled_power;
	logic [FreqOutW-1:0]  frequency_out;
	logic [TotalW-1:0]    energy_total;
	logic [TotalW-1:0]    sample_total;

	modport source (
		output valid, scaled_current, scaled_voltage, scaled_power, frequency_out,
			energy_total, sample_total,
		input  ready
	);
	modport sink (
		input  valid, scaled_current, scaled_voltage, scaled_power, frequency_out,
			energy_total, sample_total,
		output ready
	);
endinterface

`default_nettype wire

// ----- hdl/power_meter_sample_scaler.sv -----
// ----------------------------------------------------------------------------
// power_meter_sample_scaler: calibrates one metering sample set
// Scales current, voltage and power by ten over their divisors with one
// bit-serial restoring divider, and keeps a wrapping energy total.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-----------------------------------------
//  sample   | in  | valid / ready  | raw current, voltage, frequency, power, on
//  result   | out | valid / ready  | scaled values, frequency, energy, count
//  wr_*     | in  | wr_en only     | register index, 24-bit data
//
//  One divider, one quotient bit per cycle, produces 27 + 27 + 35 quotient bits
//  (+ 22 for power/10, only when scaled power is below 4000000), with a dispatch
//  step between divisions, plus accept and hand-off steps.
//  Reset clears divisors to 1, small-power drop off, energy and count to 0.
//  A done item enters the output register once free; a stalled result only holds
//  up the hand-off, the next sample is taken once the current one is handed off.
//
`default_nettype none

module power_meter_sample_scaler (
	input  wire                  clk,
	input  wire                  arst_n,
	pms_sample_if.sink           sample,
	pms_result_if.source         result,
	input  wire                  wr_en,
	input  pms_pkg::cfg_idx_t    wr_index,
	input  pms_pkg::cfg_data_t   wr_data
);
	import pms_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StRun  = 2'd1;
	localparam logic [1:0] StDone = 2'd2;

	localparam logic [2:0] PhLoad   = 3'd0;
	localparam logic [2:0] PhCur    = 3'd1;
	localparam logic [2:0] PhVolt   = 3'd2;
	localparam logic [2:0] PhPwr    = 3'd3;
	localparam logic [2:0] PhEnergy = 3'd4;

	// configuration
	logic [DvsrW-1:0] cur_div_q, volt_div_q, pwr_div_q;
	logic             drop_q;

	// control
	logic [1:0]       state_q;
	logic [2:0]       phase_q;
	logic [CntW-1:0]  cnt_q;

	// captured sample
	logic [CurW-2:0]     cur_q;
	logic [VoltW-2:0]    volt_q;
	logic [PwrW-2:0]     pwr_q;
	logic [FreqOutW-1:0] freq_q;
	logic                on_q;

	// divider
	logic [DivW-1:0]  dvd_q;
	logic [DvsrW-1:0] rem_q;
	logic [DvsrW-1:0] dvsr_sel, dvsr;
	logic [DvsrW+1:0] diff;
	logic             ge;

	// partial results and state
	logic [ScaledW-1:0] sc_q, sv_q;
	logic [PwrW-1:0]    sp_q;
	logic [TotalW-1:0]  energy_q, samples_q;

	// output register
	logic                out_valid_q;
	logic [ScaledW-1:0]  out_sc_q, out_sv_q;
	logic [PwrW-1:0]     out_sp_q;
	logic [FreqOutW-1:0] out_freq_q;
	logic [TotalW-1:0]   out_energy_q, out_samples_q;

	logic [ScaledW-1:0] volt10;
	logic [ScaledW-1:0] cur10;
	logic [DivW-1:0]    pwr10;
	logic [PwrW-1:0]    sp_sat, sp_final;

	assign sample.ready = (state_q == StIdle);

	always_comb begin
		unique case (phase_q)
			PhCur:    dvsr_sel = cur_div_q;
			PhVolt:   dvsr_sel = volt_div_q;
			PhPwr:    dvsr_sel = pwr_div_q;
			PhEnergy: dvsr_sel = ScaleDivisor;
			default:  dvsr_sel = ScaleDivisor;
		endcase
		// a divisor written as zero acts as one
		dvsr = (dvsr_sel == '0) ? DvsrW'(1) : dvsr_sel;
	end

	// one restoring step: shift the next dividend bit into the remainder
	assign diff = {1'b0, rem_q, dvd_q[DivW-1]} - {2'b00, dvsr};
	assign ge   = ~diff[DvsrW+1];

	// ten times = eight times plus two times
	assign cur10  = {cur_q, 4'b0000} - {1'b0, cur_q, 3'b000} + {3'b000, cur_q, 1'b0};
	assign volt10 = {volt_q, 4'b0000} - {1'b0, volt_q, 3'b000} + {3'b000, volt_q, 1'b0};
	assign pwr10  = {1'b0, pwr_q, 3'b000} + {3'b000, pwr_q, 1'b0};

	always_comb begin
		sp_sat = (dvd_q[DivW-1:PwrW] != '0) ? '1 : dvd_q[PwrW-1:0];
		sp_final = sp_sat;
		if (drop_q && (sp_sat < SmallPower)) begin
			sp_final = '0;
		end
		if (!on_q) begin
			sp_final = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_div_q  <= DvsrW'(1);
			volt_div_q <= DvsrW'(1);
			pwr_div_q  <= DvsrW'(1);
			drop_q     <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				CfgCurrentDivisor: cur_div_q  <= wr_data;
				CfgVoltageDivisor: volt_div_q <= wr_data;
				CfgPowerDivisor:   pwr_div_q  <= wr_data;
				CfgDropSmallPower: drop_q     <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			phase_q   <= PhLoad;
			cnt_q     <= '0;
			energy_q  <= '0;
			samples_q <= '0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (sample.valid) begin
						state_q <= StRun;
						phase_q <= PhLoad;
						cnt_q   <= '0;
					end
				end
				StRun: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CntW'(1);
					end else begin
						unique case (phase_q)
							PhLoad: begin
								cnt_q   <= NarrowSteps;
								phase_q <= PhCur;
							end
							PhCur: begin
								cnt_q   <= NarrowSteps;
								phase_q <= PhVolt;
							end
							PhVolt: begin
								cnt_q   <= WideSteps;
								phase_q <= PhPwr;
							end
							PhPwr: begin
								if (sp_final < PowerLimit) begin
									cnt_q   <= EnergySteps;
									phase_q <= PhEnergy;
								end else begin
									state_q <= StDone;
								end
							end
							PhEnergy: begin
								energy_q  <= energy_q + {10'd0, dvd_q[21:0]};
								samples_q <= samples_q + TotalW'(1);
								state_q   <= StDone;
							end
							default: state_q <= StIdle;
						endcase
					end
				end
				StDone: begin
					if (!out_valid_q || result.ready) begin
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// sample capture, divider datapath and partial results
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			cur_q  <= sample.raw_current[CurW-1] ? '0 : sample.raw_current[CurW-2:0];
			volt_q <= sample.raw_voltage[VoltW-1] ? '0 : sample.raw_voltage[VoltW-2:0];
			pwr_q  <= sample.raw_power[PwrW-1] ? '0 : sample.raw_power[PwrW-2:0];
			freq_q <= sample.raw_frequency[FreqW-1] ? '0 : sample.raw_frequency[FreqW-2:0];
			on_q   <= sample.outlet_on;
		end
		if (state_q == StRun) begin
			if (cnt_q != '0) begin
				rem_q <= ge ? diff[DvsrW-1:0] : {rem_q[DvsrW-2:0], dvd_q[DivW-1]};
				dvd_q <= {dvd_q[DivW-2:0], ge};
			end else begin
				rem_q <= '0;
				// dividends are left-aligned so the quotient ends in the low bits
				unique case (phase_q)
					PhLoad: dvd_q <= {cur10, 8'd0};
					PhCur: begin
						sc_q  <= on_q ? dvd_q[ScaledW-1:0] : '0;
						dvd_q <= {volt10, 8'd0};
					end
					PhVolt: begin
						sv_q  <= on_q ? dvd_q[ScaledW-1:0] : '0;
						dvd_q <= pwr10;
					end
					PhPwr: begin
						sp_q  <= sp_final;
						dvd_q <= {sp_final[21:0], 13'd0};
					end
					default: dvd_q <= dvd_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == StDone) && (!out_valid_q || result.ready)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == StDone) && (!out_valid_q || result.ready)) begin
			out_sc_q      <= sc_q;
			out_sv_q      <= sv_q;
			out_sp_q      <= sp_q;
			out_freq_q    <= freq_q;
			out_energy_q  <= energy_q;
			out_samples_q <= samples_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.scaled_current = out_sc_q;
	assign result.scaled_voltage = out_sv_q;
	assign result.scaled_power   = out_sp_q;
	assign result.frequency_out  = out_freq_q;
	assign result.energy_total   = out_energy_q;
	assign result.sample_total   = out_samples_q;

	// no sample taken while a division is still stepping
	a_idle_no_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StIdle) |-> (cnt_q == '0))
		else $error("sample accepted with divider busy");

	// partial remainder always below the active divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == StRun) && (cnt_q != '0)) |-> (rem_q < dvsr))
		else $error("divider remainder out of range");

	// the sample count only ever steps by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((samples_q == $past(samples_q))
			|| (samples_q == $past(samples_q) + TotalW'(1))))
		else $error("sample count jumped");

	// energy total stays put outside the run; it moves only in the energy phase
	a_energy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != StRun) |=> $stable(energy_q))
		else $error("energy changed outside the run");

endmodule

`default_nettype wire

// ----- verif/tb_power_meter_sample_scaler.sv -----
// ----------------------------------------------------------------------------
// tb_power_meter_sample_scaler: self-checking bench for the sample scaler
// Drives directed and random sample sets under several calibration settings,
// predicts every scaled reading and the running energy and sample totals, and
// checks each result item field by field with random stalls on both channels.
// ----------------------------------------------------------------------------

module tb_power_meter_sample_scaler;
	import pms_pkg::*;

	localparam int unsigned RandomItems = 1900;
	localparam int unsigned PhaseItems  = 240;

	typedef enum logic {RowSample, RowConfig} row_kind_t;

	typedef struct packed {
		logic [CurW-1:0]  raw_current;
		logic [VoltW-1:0] raw_voltage;
		logic [FreqW-1:0] raw_frequency;
		logic [PwrW-1:0]  raw_power;
		logic             outlet_on;
	} sample_t;

	typedef struct packed {
		logic [ScaledW-1:0]  scaled_current;
		logic [ScaledW-1:0]  scaled_voltage;
		logic [PwrW-1:0]     scaled_power;
		logic [FreqOutW-1:0] frequency_out;
		logic [TotalW-1:0]   energy_total;
		logic [TotalW-1:0]   sample_total;
	} reading_t;

	typedef struct {
		row_kind_t kind;
		sample_t   smp;
		cfg_data_t cur_div;
		cfg_data_t volt_div;
		cfg_data_t pwr_div;
		logic      drop;
		logic      typed;
		reading_t  want;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      wr_en;
	cfg_idx_t  wr_index;
	cfg_data_t wr_data;

	pms_sample_if smp_ch();
	pms_result_if res_ch();

	power_meter_sample_scaler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (smp_ch),
		.result   (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// bench copy of the calibration registers and the accumulators
	cfg_data_t   cal_cur_div  = 24'd1;
	cfg_data_t   cal_volt_div = 24'd1;
	cfg_data_t   cal_pwr_div  = 24'd1;
	logic        cal_drop     = 1'b0;
	logic [31:0] energy_acc   = '0;
	logic [31:0] sample_cnt   = '0;

	reading_t    pending_readings[$];
	int unsigned mismatches = 0;
	bit          steady = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("power_meter_sample_scaler verification failed");
		$finish;
	end

	function automatic logic [63:0] eff_div(cfg_data_t d);
		return (d == '0) ? 64'd1 : 64'(d);
	endfunction

	// expected reading for one accepted sample; advances the energy state
	function automatic reading_t scale_reading(sample_t s);
		reading_t    r;
		logic [63:0] cur, volt, pwr, freq, sc, sv, sp;
		cur  = s.raw_current[CurW-1] ? 64'd0 : 64'(s.raw_current);
		volt = s.raw_voltage[VoltW-1] ? 64'd0 : 64'(s.raw_voltage);
		freq = s.raw_frequency[FreqW-1] ? 64'd0 : 64'(s.raw_frequency);
		pwr  = s.raw_power[PwrW-1] ? 64'd0 : 64'(s.raw_power);
		sc = (cur * 64'(ScaleDivisor)) / eff_div(cal_cur_div);
		sv = (volt * 64'(ScaleDivisor)) / eff_div(cal_volt_div);
		sp = (pwr * 64'(ScaleDivisor)) / eff_div(cal_pwr_div);
		if (sp > 64'hFFFF_FFFF) begin
			sp = 64'hFFFF_FFFF;
		end
		if (cal_drop && sp < 64'(SmallPower)) begin
			sp = '0;
		end
		if (!s.outlet_on) begin
			sc = '0;
			sv = '0;
			sp = '0;
		end
		if (sp < 64'(PowerLimit)) begin
			energy_acc = energy_acc + 32'(sp / 64'(ScaleDivisor));
			sample_cnt = sample_cnt + 32'd1;
		end
		r.scaled_current = ScaledW'(sc);
		r.scaled_voltage = ScaledW'(sv);
		r.scaled_power   = PwrW'(sp);
		r.frequency_out  = FreqOutW'(freq);
		r.energy_total   = energy_acc;
		r.sample_total   = sample_cnt;
		return r;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// result side: random stalls, compare each item with the oldest expectation
	always @(posedge clk) begin
		reading_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.scaled_current, res_ch.scaled_voltage, res_ch.scaled_power,
				res_ch.frequency_out, res_ch.energy_total, res_ch.sample_total};
			if (pending_readings.size() == 0) begin
				$error("result item with no expectation waiting");
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				check_field("scaled_current", want.scaled_current, got.scaled_current);
				check_field("scaled_voltage", want.scaled_voltage, got.scaled_voltage);
				check_field("scaled_power", want.scaled_power, got.scaled_power);
				check_field("frequency_out", want.frequency_out, got.frequency_out);
				check_field("energy_total", want.energy_total, got.energy_total);
				check_field("sample_total", want.sample_total, got.sample_total);
			end
		end
		res_ch.ready <= (!steady && $urandom_range(99) < 8) ? 1'b0 : 1'b1;
	end

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			CfgCurrentDivisor: cal_cur_div = val;
			CfgVoltageDivisor: cal_volt_div = val;
			CfgPowerDivisor:   cal_pwr_div = val;
			CfgDropSmallPower: cal_drop = val[0];
			default: ;
		endcase
	endtask

	// only called with the block idle: every result has come back
	task automatic apply_config(cfg_data_t c, cfg_data_t v, cfg_data_t p, logic d);
		smp_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		write_reg(CfgCurrentDivisor, c);
		write_reg(CfgVoltageDivisor, v);
		write_reg(CfgPowerDivisor, p);
		write_reg(CfgDropSmallPower, cfg_data_t'(d));
		wr_en <= 1'b0;
	endtask

	task automatic send_sample(sample_t s, logic typed, reading_t want);
		reading_t predicted;
		while (!steady && $urandom_range(99) < 8) begin
			smp_ch.valid <= 1'b0;
			@(posedge clk);
		end
		smp_ch.valid         <= 1'b1;
		smp_ch.raw_current   <= s.raw_current;
		smp_ch.raw_voltage   <= s.raw_voltage;
		smp_ch.raw_frequency <= s.raw_frequency;
		smp_ch.raw_power     <= s.raw_power;
		smp_ch.outlet_on     <= s.outlet_on;
		@(posedge clk);
		while (!smp_ch.ready) @(posedge clk);
		// predictor always runs so the energy state tracks typed rows too
		predicted = scale_reading(s);
		pending_readings.push_back(typed ? want : predicted);
	endtask

	function automatic plan_row_t cfg_row(cfg_data_t c, cfg_data_t v, cfg_data_t p,
			logic d);
		plan_row_t r;
		r.kind     = RowConfig;
		r.smp      = '0;
		r.cur_div  = c;
		r.volt_div = v;
		r.pwr_div  = p;
		r.drop     = d;
		r.typed    = 1'b0;
		r.want     = '0;
		return r;
	endfunction

	function automatic plan_row_t smp_row(logic [CurW-1:0] c, logic [VoltW-1:0] v,
			logic [FreqW-1:0] f, logic [PwrW-1:0] p, logic on);
		plan_row_t r;
		r = cfg_row('0, '0, '0, 1'b0);
		r.kind = RowSample;
		r.smp  = '{c, v, f, p, on};
		return r;
	endfunction

	function automatic plan_row_t known_row(logic [CurW-1:0] c, logic [VoltW-1:0] v,
			logic [FreqW-1:0] f, logic [PwrW-1:0] p, logic on,
			logic [ScaledW-1:0] sc, logic [ScaledW-1:0] sv, logic [PwrW-1:0] sp,
			logic [FreqOutW-1:0] fo, logic [TotalW-1:0] e, logic [TotalW-1:0] n);
		plan_row_t r;
		r = smp_row(c, v, f, p, on);
		r.typed = 1'b1;
		r.want  = '{sc, sv, sp, fo, e, n};
		return r;
	endfunction

	function automatic cfg_data_t rand_divisor();
		case ($urandom_range(5))
			0: return '0;
			1: return cfg_data_t'(1);
			2: return '1;
			3: return cfg_data_t'($urandom_range(2, 100));
			4: return cfg_data_t'($urandom_range(1000, 100000));
			default: return cfg_data_t'($urandom);
		endcase
	endfunction

	// raw power that lands near a scaled target under the current divisor
	function automatic logic [PwrW-1:0] power_near(logic [PwrW-1:0] target);
		logic [63:0] p;
		p = (64'(target) * eff_div(cal_pwr_div)) / 64'(ScaleDivisor);
		p = p + 64'($urandom_range(2)) - 64'd1;
		return (p < 64'h8000_0000) ? PwrW'(p) : PwrW'($urandom_range(0, 1000));
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		s.raw_current   = CurW'($urandom >> $urandom_range(0, 8));
		s.raw_voltage   = VoltW'($urandom);
		s.raw_frequency = FreqW'($urandom);
		s.raw_power     = $urandom >> $urandom_range(0, 31);
		case ($urandom_range(7))
			0: s.raw_power = power_near(PowerLimit);
			1: s.raw_power = power_near(SmallPower);
			default: ;
		endcase
		// sign-set readings are kept rare so most items carry real values
		if ($urandom_range(9) != 0) s.raw_current[CurW-1] = 1'b0;
		if ($urandom_range(9) != 0) s.raw_voltage[VoltW-1] = 1'b0;
		if ($urandom_range(9) != 0) s.raw_frequency[FreqW-1] = 1'b0;
		if ($urandom_range(9) != 0) s.raw_power[PwrW-1] = 1'b0;
		s.outlet_on = ($urandom_range(9) != 0);
		return s;
	endfunction

	initial begin
		plan_row_t plan[$];
		arst_n               = 1'b0;
		wr_en                = 1'b0;
		wr_index             = CfgCurrentDivisor;
		wr_data              = '0;
		smp_ch.valid         = 1'b0;
		smp_ch.raw_current   = '0;
		smp_ch.raw_voltage   = '0;
		smp_ch.raw_frequency = '0;
		smp_ch.raw_power     = '0;
		smp_ch.outlet_on     = 1'b0;
		res_ch.ready         = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: divisors 1, small-power drop off
		plan.push_back(known_row(24'h0, 24'h0, 16'h0, 32'h0, 1'b1,
			27'd0, 27'd0, 32'd0, 15'd0, 32'd0, 32'd1));
		plan.push_back(known_row(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 32'h0, 1'b1,
			27'd83886070, 27'd83886070, 32'd0, 15'd32767, 32'd0, 32'd2));
		// every sign bit set reads as zero
		plan.push_back(known_row(24'h800000, 24'hFFFFFF, 16'h8000, 32'h80000000, 1'b1,
			27'd0, 27'd0, 32'd0, 15'd0, 32'd0, 32'd3));
		// saturated power, also above the accumulation limit
		plan.push_back(known_row(24'h1, 24'h1, 16'h1, 32'h7FFFFFFF, 1'b1,
			27'd10, 27'd10, 32'hFFFFFFFF, 15'd1, 32'd0, 32'd3));
		plan.push_back(known_row(24'hFFFFFF, 24'h800001, 16'hFFFF, 32'd399999, 1'b1,
			27'd0, 27'd0, 32'd3999990, 15'd0, 32'd399999, 32'd4));
		plan.push_back(known_row(24'h0, 24'h0, 16'h0, 32'd400000, 1'b1,
			27'd0, 27'd0, 32'd4000000, 15'd0, 32'd399999, 32'd4));
		// outlet off: scaled values zero, frequency still reported
		plan.push_back(known_row(24'h7FFFFF, 24'h7FFFFF, 16'h1234, 32'h7FFFFFFF, 1'b0,
			27'd0, 27'd0, 32'd0, 15'h1234, 32'd399999, 32'd5));
		plan.push_back(known_row(24'd123, 24'd4567, 16'd600, 32'd49, 1'b1,
			27'd1230, 27'd45670, 32'd490, 15'd600, 32'd400048, 32'd6));
		// zero divisors act as one, small-power drop on
		plan.push_back(cfg_row('0, '0, '0, 1'b1));
		plan.push_back(known_row(24'd5, 24'd7, 16'd50, 32'd49, 1'b1,
			27'd50, 27'd70, 32'd0, 15'd50, 32'd400048, 32'd7));
		plan.push_back(known_row(24'd0, 24'd0, 16'd0, 32'd50, 1'b1,
			27'd0, 27'd0, 32'd500, 15'd0, 32'd400098, 32'd8));
		// largest divisors
		plan.push_back(cfg_row('1, '1, '1, 1'b1));
		plan.push_back(smp_row(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 32'h7FFFFFFF, 1'b1));
		plan.push_back(smp_row(24'h1, 24'h1, 16'h1, 32'd1000, 1'b1));
		plan.push_back(smp_row(24'h555555, 24'h2AAAAA, 16'h5555, 32'h55555555, 1'b1));
		// mid-range calibration, drop off
		plan.push_back(cfg_row(24'd3, 24'd7, 24'd2, 1'b0));
		plan.push_back(smp_row(24'd12345, 24'd67890, 16'd600, 32'h7FFFFFFF, 1'b1));
		plan.push_back(smp_row(24'h2AAAAA, 24'h555555, 16'h2AAA, 32'h2AAAAAAA, 1'b1));
		plan.push_back(smp_row(24'd100, 24'd200, 16'd300, 32'd799999, 1'b1));
		plan.push_back(smp_row(24'd100, 24'd200, 16'd300, 32'd800000, 1'b1));
		plan.push_back(smp_row(24'd9, 24'd9, 16'd9, 32'd99, 1'b0));

		foreach (plan[i]) begin
			if (plan[i].kind == RowConfig) begin
				apply_config(plan[i].cur_div, plan[i].volt_div, plan[i].pwr_div,
					plan[i].drop);
			end else begin
				send_sample(plan[i].smp, plan[i].typed, plan[i].want);
			end
		end

		for (int i = 0; i < RandomItems; i++) begin
			if (i % PhaseItems == 0) begin
				apply_config(rand_divisor(), rand_divisor(), rand_divisor(),
					1'($urandom_range(1)));
			end
			steady = (i >= 700 && i < 1000);
			send_sample(rand_sample(), 1'b0, '0);
		end
		steady = 1'b0;
		smp_ch.valid <= 1'b0;

		while (pending_readings.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0) begin
			$display("power_meter_sample_scaler verification clean");
		end else begin
			$display("power_meter_sample_scaler verification failed");
		end
		$finish;
	end

endmodule
